@@ hdl/nit_pkg.sv @@
// Shared codes, constants, types and byte helpers of the name interning table.
package nit_pkg;

	localparam int OPCODE_W = 2;
	localparam int CHAR_W   = 8;
	localparam int INDEX_W  = 6;
	localparam int ID_W     = 6;

	localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd3;

	localparam logic KIND_ID   = 1'b0;
	localparam logic KIND_BYTE = 1'b1;

	localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

	localparam int DEFAULT_LEN = 7;
	localparam logic [CHAR_W-1:0] DEFAULT_TEXT [DEFAULT_LEN] =
		'{8'h44, 8'h45, 8'h46, 8'h41, 8'h55, 8'h4C, 8'h54};

	// control from the sequencer to the name assembler
	typedef struct packed {
		logic              append;
		logic              clear;
		logic [CHAR_W-1:0] char_byte;
	} asm_ctl_t;

	// space -> underscore, lower case -> upper case
	function automatic logic [CHAR_W-1:0] canon_char(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c == CH_SPACE) begin
			r = CH_UNDERSCORE;
		end else if (c inside {[8'h61:8'h7A]}) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

	// byte i of the zero padded default name
	function automatic logic [CHAR_W-1:0] default_char(input int unsigned i);
		logic [CHAR_W-1:0] r;
		r = CH_NUL;
		if (i < DEFAULT_LEN) begin
			r = DEFAULT_TEXT[i[2:0]];
		end
		return r;
	endfunction

endpackage

@@ hdl/nit_in_if.sv @@
// Request channel: opcode, name byte and read index with valid/ready.
interface nit_in_if;
	import nit_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [CHAR_W-1:0]   char_byte;
	logic [INDEX_W-1:0]  entry_index;

	modport source (output valid, output opcode, output char_byte, output entry_index,
		input ready);
	modport sink (input valid, input opcode, input char_byte, input entry_index,
		output ready);
endinterface

@@ hdl/nit_out_if.sv @@
// Result channel: id answers and name bytes with valid/ready.
interface nit_out_if;
	import nit_pkg::*;

	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [ID_W-1:0]   entry_id;
	logic [CHAR_W-1:0] name_byte;
	logic              last;

	modport source (output valid, output result_kind, output entry_id, output name_byte,
		output last, input ready);
	modport sink (input valid, input result_kind, input entry_id, input name_byte,
		input last, output ready);
endinterface

@@ hdl/nit_assembler.sv @@
// Name assembler: canonicalizes incoming bytes and builds the name row.
module nit_assembler #(
	parameter int NAME_LEN = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  nit_pkg::asm_ctl_t            ctl,
	output logic [(NAME_LEN-1)*8-1:0]    name_row
);
	import nit_pkg::*;

	localparam int KEEP_LEN = NAME_LEN - 1;
	localparam int ROW_W    = KEEP_LEN * CHAR_W;
	localparam int LEN_W    = $clog2(NAME_LEN);

	logic [CHAR_W-1:0] chars_q [KEEP_LEN];
	logic [LEN_W-1:0]  len_q;
	logic [ROW_W-1:0]  def_row;
	logic [ROW_W-1:0]  buf_row;
	logic              take;

	assign take = ctl.append && (ctl.char_byte != CH_NUL) && (len_q < LEN_W'(KEEP_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int i = 0; i < KEEP_LEN; i++) begin
				chars_q[i] <= CH_NUL;
			end
		end else if (ctl.clear) begin
			len_q <= '0;
			for (int i = 0; i < KEEP_LEN; i++) begin
				chars_q[i] <= CH_NUL;
			end
		end else if (take) begin
			for (int i = 0; i < KEEP_LEN; i++) begin
				if (len_q == LEN_W'(i)) begin
					chars_q[i] <= canon_char(ctl.char_byte);
				end
			end
			len_q <= len_q + LEN_W'(1);
		end
	end

	for (genvar g = 0; g < KEEP_LEN; g++) begin : g_row
		assign def_row[g*CHAR_W +: CHAR_W] = default_char(g);
		assign buf_row[g*CHAR_W +: CHAR_W] = chars_q[g];
	end

	// an empty name stands for the default name
	assign name_row = (len_q == '0) ? def_row : buf_row;

endmodule

@@ hdl/nit_name_store.sv @@
// Name store: one row per entry, one write and one registered read per cycle.
module nit_name_store #(
	parameter int ENTRIES  = 64,
	parameter int NAME_LEN = 16
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [$clog2(ENTRIES)-1:0]     rd_addr,
	input  logic                           wr_en,
	input  logic [$clog2(ENTRIES)-1:0]     wr_addr,
	input  logic [(NAME_LEN-1)*8-1:0]      wr_data,
	output logic [(NAME_LEN-1)*8-1:0]      rd_data
);
	import nit_pkg::*;

	localparam int KEEP_LEN = NAME_LEN - 1;
	localparam int ROW_W    = KEEP_LEN * CHAR_W;

	logic [ROW_W-1:0] mem [ENTRIES];
	logic [ROW_W-1:0] rd_q;
	logic             zero_q;
	logic [ROW_W-1:0] def_row;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q   <= mem[rd_addr];
			zero_q <= (rd_addr == '0);
		end
	end

	for (genvar g = 0; g < KEEP_LEN; g++) begin : g_def
		assign def_row[g*CHAR_W +: CHAR_W] = default_char(g);
	end

	// entry 0 is never written; it always reads as the default name
	assign rd_data = zero_q ? def_row : rd_q;

endmodule

@@ hdl/nit_seq.sv @@
// Sequencer: opcode dispatch, linear table search, append, read-out and result register.
module nit_seq #(
	parameter int ENTRIES  = 64,
	parameter int NAME_LEN = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	nit_in_if.sink                         req,
	nit_out_if.source                      rsp,
	output nit_pkg::asm_ctl_t              asm_ctl,
	input  logic [(NAME_LEN-1)*8-1:0]      name_row,
	output logic                           rd_en,
	output logic [$clog2(ENTRIES)-1:0]     rd_addr,
	output logic                           wr_en,
	output logic [$clog2(ENTRIES)-1:0]     wr_addr,
	output logic [(NAME_LEN-1)*8-1:0]      wr_data,
	input  logic [(NAME_LEN-1)*8-1:0]      rd_data
);
	import nit_pkg::*;

	localparam int KEEP_LEN = NAME_LEN - 1;
	localparam int ROW_W    = KEEP_LEN * CHAR_W;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_ANSWER = 3'd2;
	localparam logic [2:0] S_RDWAIT = 3'd3;
	localparam logic [2:0] S_EMIT   = 3'd4;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              vld_s1;
	logic [CNT_W-1:0]  idx_s1;
	logic [ROW_W-1:0]  canon_q;
	logic [ROW_W-1:0]  row_q;
	logic [ID_W-1:0]   id_q;

	logic              valid_q;
	logic              kind_q;
	logic [ID_W-1:0]   id_out_q;
	logic [CHAR_W-1:0] byte_q;
	logic              last_q;

	logic              accept;
	logic [ID_W-1:0]   rid;
	logic              search_rd;
	logic              hit;
	logic              miss;
	logic              room;
	logic              out_free;
	logic              load;
	logic [ROW_W-1:0]  row_nxt;
	logic              emit_last;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && (state_q == S_IDLE);

	// ids at or above the count read entry 0
	assign rid = (32'(req.entry_index) < 32'(count_q)) ? req.entry_index : '0;

	assign search_rd = (state_q == S_SEARCH) && (rd_idx_q < count_q);
	assign hit       = vld_s1 && (rd_data == canon_q);
	assign miss      = !vld_s1 && (rd_idx_q == count_q);
	assign room      = count_q < CNT_W'(ENTRIES);

	assign rd_en   = search_rd || (accept && (req.opcode == OP_READ));
	assign rd_addr = search_rd ? rd_idx_q[IDX_W-1:0] : IDX_W'(rid);
	assign wr_en   = (state_q == S_SEARCH) && !hit && miss && room;
	assign wr_addr = count_q[IDX_W-1:0];
	assign wr_data = canon_q;

	assign asm_ctl.append    = accept && (req.opcode == OP_APPEND);
	assign asm_ctl.clear     = accept && (req.opcode == OP_LOOKUP);
	assign asm_ctl.char_byte = req.char_byte;

	assign out_free  = !valid_q || rsp.ready;
	assign load      = ((state_q == S_ANSWER) || (state_q == S_EMIT)) && out_free;
	assign row_nxt   = row_q >> CHAR_W;
	assign emit_last = (row_nxt[CHAR_W-1:0] == CH_NUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= CNT_W'(1);
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			vld_s1 <= search_rd;
			if (search_rd) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.opcode)
							OP_LOOKUP: begin
								state_q  <= S_SEARCH;
								rd_idx_q <= '0;
							end
							OP_READ:  state_q <= S_RDWAIT;
							OP_CLEAR: count_q <= CNT_W'(1);
							default: ;
						endcase
					end
				end
				S_SEARCH: begin
					if (hit) begin
						state_q <= S_ANSWER;
					end else if (miss) begin
						if (room) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_ANSWER;
					end
				end
				S_ANSWER: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RDWAIT: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free && emit_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (asm_ctl.clear) begin
			canon_q <= name_row;
		end
		if (accept && (req.opcode == OP_READ)) begin
			id_q <= rid;
		end else if ((state_q == S_SEARCH) && hit) begin
			id_q <= ID_W'(idx_s1);
		end else if ((state_q == S_SEARCH) && miss) begin
			id_q <= room ? ID_W'(count_q) : '0;
		end
		if (state_q == S_RDWAIT) begin
			row_q <= rd_data;
		end else if ((state_q == S_EMIT) && out_free) begin
			row_q <= row_nxt;
		end
		if (load) begin
			id_out_q <= id_q;
			if (state_q == S_EMIT) begin
				kind_q <= KIND_BYTE;
				byte_q <= row_q[CHAR_W-1:0];
				last_q <= emit_last;
			end else begin
				kind_q <= KIND_ID;
				byte_q <= CH_NUL;
				last_q <= 1'b1;
			end
		end
	end

	assign rsp.valid       = valid_q;
	assign rsp.result_kind = kind_q;
	assign rsp.entry_id    = id_out_q;
	assign rsp.name_byte   = byte_q;
	assign rsp.last        = last_q;

endmodule

@@ hdl/name_interning_table.sv @@
// Name interning table top level: assembler, name store and sequencer.
//
// Names arrive one byte word at a time (opcode append) and are made canonical
// on the way in: space turns into underscore, a..z into A..Z, NUL bytes are
// dropped and only the first NAME_LEN-1 bytes are kept. An end-of-name word
// (opcode lookup) compares the assembled name, or DEFAULT when nothing was
// assembled, against every live entry and answers with one id word: the
// matching id, a freshly appended id, or 0 when the table is full. A read
// word returns the stored name as one byte word per character, last set on
// the final one; an id at or above the entry count reads entry 0, which is
// always DEFAULT. Clear drops all entries but entry 0 and keeps a partly
// assembled name. Append and clear leave the sequencer idle. Lookup walks the
// name store one row per cycle through its single read port; on a hit or a
// miss (append or full table) the answer state loads the id word into the
// output register once the result side is free, and the next request word
// can be taken in the cycle after. A read fetches the row into a row register
// and emits its bytes first character first while the result side takes them.
// Results leave through an output register; a new request word is taken only
// when the sequencer is idle. No clearing pass is needed after reset: entry 0
// is a constant and the entry count bounds every access to the store.
module name_interning_table #(
	parameter int ENTRIES  = 64,
	parameter int NAME_LEN = 16
) (
	input logic        clk,
	input logic        arst_n,
	nit_in_if.sink     req,
	nit_out_if.source  rsp
);
	import nit_pkg::*;

	localparam int KEEP_LEN = NAME_LEN - 1;
	localparam int ROW_W    = KEEP_LEN * CHAR_W;
	localparam int IDX_W    = $clog2(ENTRIES);

	asm_ctl_t          asm_ctl;
	logic [ROW_W-1:0]  name_row;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [ROW_W-1:0]  wr_data;
	logic [ROW_W-1:0]  rd_data;

	// byte canonicalization and name buffer
	nit_assembler #(
		.NAME_LEN (NAME_LEN)
	) u_asm (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (asm_ctl),
		.name_row (name_row)
	);

	// one row of KEEP_LEN bytes per entry
	nit_name_store #(
		.ENTRIES  (ENTRIES),
		.NAME_LEN (NAME_LEN)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// dispatch, search / append, read-out, result register
	nit_seq #(
		.ENTRIES  (ENTRIES),
		.NAME_LEN (NAME_LEN)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.asm_ctl  (asm_ctl),
		.name_row (name_row),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_data  (rd_data)
	);

endmodule
